[src/epds_pkg.sv]
`timescale 1ns / 1ps
package epds_pkg;
   localparam int MaxWidth    = 256;
   localparam int MaxHeight   = 256;
   localparam int StoreDepth  = MaxWidth * MaxHeight;
   localparam int AddrWidth   = $clog2(StoreDepth);
   localparam int ColWidth    = $clog2(MaxWidth + 1);
   localparam int RowWidth    = $clog2(MaxHeight + 1);

   typedef logic [15:0] pixel_type;
   typedef logic [AddrWidth-1:0] addr_type;

   typedef enum logic [2:0] {
      REG_ALPHA  = 3'd0,
      REG_DELTA  = 3'd1,
      REG_ITER   = 3'd2,
      REG_HOLE   = 3'd3,
      REG_WIDTH  = 3'd4,
      REG_HEIGHT = 3'd5
   } reg_index_type;

   function automatic pixel_type mix(pixel_type v1, pixel_type v0, logic [8:0] a);
      logic [25:0] acc;
      acc = 26'(v1) * 26'(a) + 26'(v0) * 26'(9'd256 - a) + 26'd128;
      return acc[23:8];
   endfunction

   function automatic pixel_type absdiff(pixel_type x, pixel_type y);
      return (x > y) ? x - y : y - x;
   endfunction
endpackage

[src/epds_req_if.sv]
`timescale 1ns / 1ps
interface epds_req_if;
   logic             valid;
   logic             ready;
   logic [15:0]      depth_in;
   modport source (output valid, depth_in, input ready);
   modport sink   (input valid, depth_in, output ready);
endinterface

[src/epds_rsp_if.sv]
`timescale 1ns / 1ps
interface epds_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] depth_out;
   logic        out_valid;
   logic        frame_end;
   modport source (output valid, depth_out, out_valid, frame_end, input ready);
   modport sink   (input valid, depth_out, out_valid, frame_end, output ready);
endinterface

[src/epds_csr_if.sv]
`timescale 1ns / 1ps
interface epds_csr_if;
   logic        valid;
   logic        ready;
   logic [7:0]  index;
   logic [15:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

[src/edge_preserving_depth_smooth_unit.sv]
`timescale 1ns / 1ps
// channel  dir  payload                              handshake
// req      in   depth_in[15:0]                       req.valid/req.ready
// rsp      out  depth_out[15:0] out_valid frame_end  rsp.valid/rsp.ready
// csr      in   index[7:0] data[15:0]                csr.valid/csr.ready
// A pixel beat reads the stores and then writes the load store when no frame ends;
// the next beat is taken while a result waits, its result then waits in ST_PIX.
// The last pixel of a frame starts the filter: a copy of all w*h pixels, then per
// iteration steps of ST_ROW, ST_RD0, ST_RD1, ST_CALC, ST_NEXT, (2*w-3)*h horizontal and
// 2*(h-1)*w vertical, then ST_DONE. No req or csr beat is taken meanwhile.
// Reset is synchronous; stores are not cleared. rsp holds while stalled.
module edge_preserving_depth_smooth_unit (
   input  logic clock,
   input  logic reset,
   epds_req_if.sink   req,
   epds_rsp_if.source rsp,
   epds_csr_if.sink   csr
);
   typedef enum logic [3:0] {
      ST_IDLE, ST_PIX, ST_COPY_RD, ST_COPY_WR, ST_ROW, ST_RD0, ST_RD1, ST_CALC,
      ST_NEXT, ST_DONE
   } state_type;

   typedef enum logic [1:0] {P_HLR, P_HRL, P_VTD, P_VBU} pass_type;

   logic [8:0]  alpha_ff;
   logic [15:0] delta_ff;
   logic [2:0]  iter_ff;
   logic [7:0]  hole_ff;
   logic [8:0]  width_ff, height_ff;

   state_type   state_ff;
   pass_type    pass_ff;
   logic [15:0] pos_ff;
   logic        have_ff;
   logic        end_ff;
   logic [15:0] span_ff;
   logic [2:0]  k_ff;
   logic [epds_pkg::ColWidth-1:0] col_ff;
   logic [epds_pkg::RowWidth-1:0] row_ff;
   logic [15:0] fill_ff;
   epds_pkg::pixel_type v0_ff, v1_ff, pix_ff;
   epds_pkg::addr_type  addr_ff, rd_addr, wr_addr;
   logic        out_full_ff;
   logic        rsp_load, out_full_in;
   epds_pkg::pixel_type old_pix;

   epds_pkg::pixel_type load_mem [epds_pkg::StoreDepth];
   epds_pkg::pixel_type res_mem  [epds_pkg::StoreDepth];
   epds_pkg::pixel_type load_q_ff, res_q_ff, wr_data;
   logic        res_we, load_rd;
   epds_pkg::addr_type  res_rd_addr;

   logic [8:0] w_use, h_use, a_use;
   logic [16:0] last_pos;
   always_comb begin
      w_use = (width_ff < 9'd3) ? 9'd3 : (width_ff > 9'(epds_pkg::MaxWidth) ?
              9'(epds_pkg::MaxWidth) : width_ff);
      h_use = (height_ff < 9'd2) ? 9'd2 : (height_ff > 9'(epds_pkg::MaxHeight) ?
              9'(epds_pkg::MaxHeight) : height_ff);
      a_use = (alpha_ff > 9'd256) ? 9'd256 : alpha_ff;
      last_pos = 17'(18'(w_use) * 18'(h_use) - 18'd1);
   end

   assign csr.ready = (state_ff == ST_IDLE);
   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_ff <= 9'd128; delta_ff <= 16'd20; iter_ff <= 3'd2;
         hole_ff <= 8'd0; width_ff <= 9'd256; height_ff <= 9'd256;
      end else if (csr.valid && csr.ready) begin
         case (csr.index)
            8'(epds_pkg::REG_ALPHA):  alpha_ff  <= csr.data[8:0];
            8'(epds_pkg::REG_DELTA):  delta_ff  <= csr.data;
            8'(epds_pkg::REG_ITER):   iter_ff   <= csr.data[2:0];
            8'(epds_pkg::REG_HOLE):   hole_ff   <= csr.data[7:0];
            8'(epds_pkg::REG_WIDTH):  width_ff  <= csr.data[8:0];
            8'(epds_pkg::REG_HEIGHT): height_ff <= csr.data[8:0];
            default: ;
         endcase
      end
   end

   // address of (row, col) in current geometry
   function automatic epds_pkg::addr_type at(logic [epds_pkg::RowWidth-1:0] r,
                                             logic [8:0] c, logic [8:0] w);
      return epds_pkg::AddrWidth'(18'(r) * 18'(w) + 18'(c));
   endfunction

   // neighbor and target addresses per pass
   epds_pkg::addr_type a_nb, a_tg;
   always_comb begin
      case (pass_ff)
         P_HLR: begin a_nb = at(row_ff, 9'(col_ff) - 9'd1, w_use);
                      a_tg = at(row_ff, 9'(col_ff), w_use); end
         P_HRL: begin a_nb = at(row_ff, 9'(col_ff) + 9'd1, w_use);
                      a_tg = at(row_ff, 9'(col_ff), w_use); end
         P_VTD: begin a_nb = at(row_ff - 1'b1, 9'(col_ff), w_use);
                      a_tg = at(row_ff, 9'(col_ff), w_use); end
         default: begin a_nb = at(row_ff + 1'b1, 9'(col_ff), w_use);
                      a_tg = at(row_ff, 9'(col_ff), w_use); end
      endcase
   end

   // compute step
   epds_pkg::pixel_type d, new_v;
   logic do_wr;
   logic [15:0] fill_next;
   always_comb begin
      d = epds_pkg::absdiff(v1_ff, v0_ff);
      new_v = v1_ff; do_wr = 1'b0; fill_next = fill_ff;
      case (pass_ff)
         P_HLR, P_HRL: begin
            if (v0_ff != '0) begin
               if (v1_ff != '0) begin
                  fill_next = '0;
                  if (d >= 16'd1 && d <= delta_ff) begin
                     new_v = epds_pkg::mix(v1_ff, v0_ff, a_use); do_wr = 1'b1;
                  end
               end else if (hole_ff != 8'd0) begin
                  if (fill_ff != 16'hFFFF) fill_next = fill_ff + 16'd1;
                  if (fill_next < 16'(hole_ff)) begin
                     new_v = v0_ff; do_wr = 1'b1;
                  end
               end
            end
         end
         P_VTD: if (d < delta_ff) begin
            new_v = epds_pkg::mix(v1_ff, v0_ff, a_use); do_wr = 1'b1;
         end
         default: if (v0_ff != '0 && v1_ff != '0 && d < delta_ff) begin
            new_v = epds_pkg::mix(v1_ff, v0_ff, a_use); do_wr = 1'b1;
         end
      endcase
   end

   // memory control
   always_comb begin
      res_rd_addr = addr_ff; res_we = 1'b0; wr_addr = addr_ff; wr_data = new_v;
      load_rd = 1'b0; rd_addr = addr_ff;
      case (state_ff)
         ST_IDLE: begin res_rd_addr = pos_ff; load_rd = 1'b1; rd_addr = pos_ff; end
         ST_COPY_RD: load_rd = 1'b1;
         ST_COPY_WR: begin res_we = 1'b1; wr_data = load_q_ff; end
         ST_ROW:  res_rd_addr = a_nb;
         ST_RD0:  res_rd_addr = a_tg;
         ST_CALC: begin res_we = do_wr; wr_addr = a_tg; end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (load_rd) load_q_ff <= load_mem[rd_addr];
      if (state_ff == ST_PIX) load_mem[addr_ff] <= pix_ff;
      if (res_we) res_mem[wr_addr] <= wr_data;
      res_q_ff <= res_mem[res_rd_addr];
   end

   assign req.ready = (state_ff == ST_IDLE);
   assign rsp.valid = out_full_ff;

   // past the last filtered span the previous frame holds the raw pixels
   always_comb begin
      rsp_load = (state_ff == ST_PIX) && (!out_full_ff || rsp.ready);
      out_full_in = rsp_load || (out_full_ff && !rsp.ready);
      old_pix = (span_ff >= addr_ff) ? res_q_ff : load_q_ff;
   end

   logic [8:0] wm1, wm2;
   assign wm1 = w_use - 9'd1;
   assign wm2 = w_use - 9'd2;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE; pos_ff <= '0; have_ff <= 1'b0; out_full_ff <= 1'b0;
         pass_ff <= P_HLR; k_ff <= '0; col_ff <= '0; row_ff <= '0; fill_ff <= '0;
         span_ff <= '0;
      end else begin
         out_full_ff <= out_full_in;
         case (state_ff)
            ST_IDLE: if (req.valid && req.ready) begin
               pix_ff <= req.depth_in;
               addr_ff <= epds_pkg::AddrWidth'(pos_ff);
               end_ff <= (17'(pos_ff) >= last_pos);
               state_ff <= ST_PIX;
            end
            ST_PIX: if (rsp_load) begin
               rsp.depth_out <= have_ff ? old_pix : '0;
               rsp.out_valid <= have_ff;
               rsp.frame_end <= end_ff;
               if (end_ff) begin
                  pos_ff <= '0; have_ff <= 1'b1; addr_ff <= '0;
                  span_ff <= 16'(last_pos);
                  state_ff <= ST_COPY_RD;
               end else begin
                  pos_ff <= pos_ff + 16'd1; state_ff <= ST_IDLE;
               end
            end
            ST_COPY_RD: state_ff <= ST_COPY_WR;
            ST_COPY_WR: begin
               if (17'(addr_ff) == last_pos) begin
                  k_ff <= '0; pass_ff <= P_HLR; row_ff <= '0;
                  col_ff <= epds_pkg::ColWidth'(1);
                  fill_ff <= '0;
                  state_ff <= (iter_ff == 3'd0) ? ST_DONE : ST_ROW;
               end else begin
                  addr_ff <= addr_ff + 1'b1; state_ff <= ST_COPY_RD;
               end
            end
            ST_ROW: state_ff <= ST_RD0;
            ST_RD0: begin v0_ff <= res_q_ff; state_ff <= ST_RD1; end
            ST_RD1: begin v1_ff <= res_q_ff; state_ff <= ST_CALC; end
            ST_CALC: begin
               case (pass_ff)
                  P_HLR: begin
                     fill_ff <= fill_next;
                     state_ff <= ST_NEXT;
                     if (9'(col_ff) == wm2) begin
                        pass_ff <= P_HRL; col_ff <= epds_pkg::ColWidth'(wm2);
                     end else begin
                        col_ff <= col_ff + 1'b1;
                     end
                  end
                  P_HRL: begin
                     state_ff <= ST_NEXT;
                     if (col_ff == '0) begin
                        fill_ff <= '0;
                        if (9'(row_ff) == h_use - 9'd1) begin
                           pass_ff <= P_VTD; row_ff <= epds_pkg::RowWidth'(1);
                           col_ff <= '0;
                        end else begin
                           pass_ff <= P_HLR; row_ff <= row_ff + 1'b1;
                           col_ff <= epds_pkg::ColWidth'(1);
                        end
                     end else begin
                        fill_ff <= fill_next; col_ff <= col_ff - 1'b1;
                     end
                  end
                  P_VTD: begin
                     state_ff <= ST_NEXT;
                     if (9'(col_ff) == wm1) begin
                        col_ff <= '0;
                        if (9'(row_ff) == h_use - 9'd1) begin
                           pass_ff <= P_VBU; row_ff <= row_ff - 1'b1;
                        end else begin
                           row_ff <= row_ff + 1'b1;
                        end
                     end else begin
                        col_ff <= col_ff + 1'b1;
                     end
                  end
                  default: begin
                     if (9'(col_ff) != wm1) begin
                        state_ff <= ST_NEXT; col_ff <= col_ff + 1'b1;
                     end else if (row_ff != '0) begin
                        state_ff <= ST_NEXT; col_ff <= '0; row_ff <= row_ff - 1'b1;
                     end else begin
                        pass_ff <= P_HLR; col_ff <= epds_pkg::ColWidth'(1);
                        fill_ff <= '0;
                        k_ff <= k_ff + 1'b1;
                        state_ff <= (k_ff + 1'b1 == iter_ff) ? ST_DONE : ST_NEXT;
                     end
                  end
               endcase
            end
            ST_NEXT: state_ff <= ST_ROW;
            ST_DONE: state_ff <= ST_IDLE;
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // horizontal passes use the stored (possibly updated) neighbor, which
   // is read back after write, so the recursion holds through memory.

   a_busy_no_req: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !req.ready) else $error("req ready while busy");
   a_one_out: assert property (@(posedge clock) disable iff (reset)
      (req.valid && req.ready) |=> !req.ready) else $error("second beat taken");
   a_rsp_after: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PIX) |=> rsp.valid) else $error("result missing");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && !rsp.ready) |=> (rsp.valid && $stable(rsp.depth_out) &&
      $stable(rsp.out_valid) && $stable(rsp.frame_end)))
      else $error("rsp changed while stalled");
endmodule
